// ===== design/ipv6_text_address_parser_top_assert.svh =====
// Assertion macros for the IPv6 text address parser checker.
// Depends on nothing; included by the checker file.
`ifndef IPV6_TEXT_ADDRESS_PARSER_TOP_ASSERT_SVH
`define IPV6_TEXT_ADDRESS_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define IPV6P_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define IPV6P_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ipv6p_pkg.sv =====
// Shared widths, character codes and register codes for the IPv6 text parser.
// No dependencies; used by the interfaces, the top level and the checker.
package ipv6p_pkg;

  localparam int CHAR_W     = 8;
  localparam int GROUP_W    = 16;
  localparam int NUM_GROUPS = 8;
  localparam int HALF_W     = 64;
  localparam int PLEN_W     = 9;
  localparam int MODE_W     = 2;
  localparam int PFX_W      = 10;

  localparam int MAX_ADDR_CHARS_DEF = 39;
  localparam int PREFIX_MAX         = 128;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register indexes (word address)
  localparam logic [APB_ADDR_W-3:0] REG_PREFIX_MODE = '0;

  // prefix_mode codes
  localparam logic [MODE_W-1:0] MODE_NO_SLASH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_IGNORE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PARSE    = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Prefix length when absent
  localparam logic signed [PLEN_W-1:0] PLEN_NONE = -9'sd1;

endpackage

// ===== design/ipv6p_char_if.sv =====
// Character channel: one text character per beat with an end-of-text flag.
// Depends on ipv6p_pkg.
interface ipv6p_char_if;
  logic                          valid;
  logic                          ready;
  logic [ipv6p_pkg::CHAR_W-1:0]  char_code;
  logic                          is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== design/ipv6p_result_if.sv =====
// Result channel: one 64-bit address half per beat plus status fields.
// Depends on ipv6p_pkg.
interface ipv6p_result_if;
  logic                                valid;
  logic                                ready;
  logic [ipv6p_pkg::HALF_W-1:0]        addr_half;
  logic                                half_index;
  logic                                parse_ok;
  logic signed [ipv6p_pkg::PLEN_W-1:0] prefix_len;
  logic                                final_result;

  modport source (output valid, output addr_half, output half_index, output parse_ok,
                  output prefix_len, output final_result, input ready);
  modport sink   (input valid, input addr_half, input half_index, input parse_ok,
                  input prefix_len, input final_result, output ready);
endinterface

// ===== design/ipv6_text_address_parser_top.sv =====
// IPv6 text address parser. Takes one character per cycle unless stalled; each beat
// updates the group, gap and error registers, so the sustained rate is one character
// per clock while the input is not stalled. The beat marked is_last produces two result
// beats (address bytes 0..7, then 8..15), loaded into the result pair register; the pair
// register and a one-deep skid of finished pairs let characters keep flowing while
// results wait. The input stalls only while both the output pair and the skid hold
// unsent results. Depends on ipv6p_pkg, ipv6p_char_if and ipv6p_result_if.
module ipv6_text_address_parser_top #(
  parameter int MAX_ADDR_CHARS = ipv6p_pkg::MAX_ADDR_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  ipv6p_char_if.sink                        chars,
  ipv6p_result_if.source                    result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ipv6p_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ipv6p_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ipv6p_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);

  localparam int AC_W = $clog2(MAX_ADDR_CHARS + 2);
  localparam int GW   = ipv6p_pkg::GROUP_W;
  localparam int HW   = ipv6p_pkg::HALF_W;
  localparam int PW   = ipv6p_pkg::PLEN_W;
  localparam int FW   = ipv6p_pkg::PFX_W;

  typedef enum logic [2:0] {
    PH_NEW, PH_FIELD, PH_COLON, PH_PFX_DIG, PH_SKIP, PH_PFX_REST
  } phase_t;

  // Hex digit decode: {valid, value}
  function automatic logic [4:0] hex_digit(input logic [ipv6p_pkg::CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    return r;
  endfunction

  // Configuration register
  logic [ipv6p_pkg::MODE_W-1:0] prefix_mode;
  logic                         cfg_wr;
  logic [ipv6p_pkg::APB_ADDR_W-3:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ipv6p_pkg::APB_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (cfg_idx == ipv6p_pkg::REG_PREFIX_MODE) ?
                   {{(ipv6p_pkg::APB_DATA_W-ipv6p_pkg::MODE_W){1'b0}}, prefix_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode <= ipv6p_pkg::MODE_NO_SLASH;
    end else if (cfg_wr && cfg_idx == ipv6p_pkg::REG_PREFIX_MODE) begin
      prefix_mode <= pwdata[ipv6p_pkg::MODE_W-1:0];
    end
  end

  // Parse state
  logic [GW-1:0]   group_store [ipv6p_pkg::NUM_GROUPS];
  logic [3:0]      group_count;
  logic [GW-1:0]   segment_value;
  logic [2:0]      segment_digits;
  logic [3:0]      gap_position;
  logic            gap_seen;
  phase_t          parse_phase;
  logic [AC_W-1:0] address_chars;
  logic            error_flag;
  logic [FW-1:0]   prefix_value;
  logic [2:0]      prefix_chars;

  // Next-state values
  logic [3:0]      group_count_next;
  logic [GW-1:0]   segment_value_next;
  logic [2:0]      segment_digits_next;
  logic [3:0]      gap_position_next;
  logic            gap_seen_next;
  phase_t          parse_phase_next;
  logic [AC_W-1:0] address_chars_next;
  logic            error_flag_next;
  logic [FW-1:0]   prefix_value_next;
  logic [2:0]      prefix_chars_next;
  logic            wr_en;
  logic [2:0]      wr_idx;
  logic [GW-1:0]   wr_val;

  // Final result of the text
  logic            fin_ok;
  logic [HW-1:0]   fin_h0;
  logic [HW-1:0]   fin_h1;
  logic signed [PW-1:0] fin_plen;

  logic            in_fire;
  logic [ipv6p_pkg::CHAR_W-1:0] c;
  assign c = chars.char_code;

  // Per-character update and end-of-text assembly
  always_comb begin
    logic         in_addr;
    logic [4:0]   hd;
    logic [3:0]   k;
    logic [4:0]   gap_end;
    logic [4:0]   src;
    logic [GW-1:0] v;
    logic [GW-1:0] gs_cur [ipv6p_pkg::NUM_GROUPS];
    logic [2*HW-1:0] flat;

    group_count_next    = group_count;
    segment_value_next  = segment_value;
    segment_digits_next = segment_digits;
    gap_position_next   = gap_position;
    gap_seen_next       = gap_seen;
    parse_phase_next    = parse_phase;
    address_chars_next  = address_chars;
    error_flag_next     = error_flag;
    prefix_value_next   = prefix_value;
    prefix_chars_next   = prefix_chars;
    wr_en  = 1'b0;
    wr_idx = group_count[2:0];
    wr_val = segment_value;
    hd     = hex_digit(c);
    in_addr = (parse_phase == PH_NEW) || (parse_phase == PH_FIELD) ||
              (parse_phase == PH_COLON);

    if (in_addr) begin
      if (c == ipv6p_pkg::CHAR_NUL ||
          (c == ipv6p_pkg::CHAR_SLASH && prefix_mode != ipv6p_pkg::MODE_NO_SLASH)) begin
        // End of address: close an open field
        if (parse_phase_next == PH_FIELD) begin
          if (group_count_next >= 4'(ipv6p_pkg::NUM_GROUPS)) begin
            error_flag_next  = 1'b1;
            parse_phase_next = PH_SKIP;
          end else begin
            wr_en  = 1'b1;
            wr_idx = group_count_next[2:0];
            wr_val = segment_value_next;
            group_count_next    = group_count_next + 4'd1;
            segment_value_next  = '0;
            segment_digits_next = '0;
          end
        end
        if (!error_flag_next) begin
          if (c == ipv6p_pkg::CHAR_SLASH && prefix_mode >= ipv6p_pkg::MODE_PARSE) begin
            parse_phase_next  = PH_PFX_DIG;
            prefix_chars_next = 3'd1;
          end else begin
            parse_phase_next = PH_SKIP;
          end
        end
      end else begin
        // Address character
        if (address_chars <= AC_W'(MAX_ADDR_CHARS)) begin
          address_chars_next = address_chars + AC_W'(1);
        end
        if (address_chars_next > AC_W'(MAX_ADDR_CHARS)) begin
          error_flag_next  = 1'b1;
          parse_phase_next = PH_SKIP;
        end else if (c == ipv6p_pkg::CHAR_COLON) begin
          if (parse_phase == PH_COLON) begin
            // Double colon
            if (gap_seen) begin
              error_flag_next  = 1'b1;
              parse_phase_next = PH_SKIP;
            end else begin
              gap_seen_next     = 1'b1;
              gap_position_next = group_count;
              parse_phase_next  = PH_NEW;
            end
          end else begin
            if (group_count >= 4'(ipv6p_pkg::NUM_GROUPS)) begin
              error_flag_next  = 1'b1;
              parse_phase_next = PH_SKIP;
            end else begin
              wr_en  = 1'b1;
              wr_idx = group_count[2:0];
              wr_val = segment_value;
              group_count_next    = group_count + 4'd1;
              segment_value_next  = '0;
              segment_digits_next = '0;
              parse_phase_next    = PH_COLON;
            end
          end
        end else if (hd[4]) begin
          if (parse_phase != PH_FIELD) begin
            segment_value_next  = '0;
            segment_digits_next = '0;
          end
          segment_digits_next = segment_digits_next + 3'd1;
          if (segment_digits_next > 3'd4) begin
            error_flag_next  = 1'b1;
            parse_phase_next = PH_SKIP;
          end else begin
            segment_value_next = {segment_value_next[GW-5:0], hd[3:0]};
            parse_phase_next   = PH_FIELD;
          end
        end else begin
          error_flag_next  = 1'b1;
          parse_phase_next = PH_SKIP;
        end
      end
    end else if (parse_phase == PH_PFX_DIG || parse_phase == PH_PFX_REST) begin
      // Prefix text
      if (c == ipv6p_pkg::CHAR_NUL) begin
        parse_phase_next = PH_SKIP;
      end else begin
        if (prefix_chars < 3'd7) prefix_chars_next = prefix_chars + 3'd1;
        if (prefix_chars_next > 3'd4) begin
          error_flag_next = 1'b1;
        end else if (parse_phase == PH_PFX_DIG && c >= ipv6p_pkg::CHAR_ZERO &&
                     c <= ipv6p_pkg::CHAR_NINE) begin
          prefix_value_next = (prefix_value << 3) + (prefix_value << 1) +
                              FW'(c - ipv6p_pkg::CHAR_ZERO);
        end else begin
          parse_phase_next = PH_PFX_REST;
        end
      end
    end

    // End of text: close the last field
    if (chars.is_last && parse_phase_next == PH_FIELD) begin
      if (group_count_next >= 4'(ipv6p_pkg::NUM_GROUPS)) begin
        error_flag_next = 1'b1;
      end else begin
        wr_en  = 1'b1;
        wr_idx = group_count_next[2:0];
        wr_val = segment_value_next;
        group_count_next = group_count_next + 4'd1;
      end
    end
    if (prefix_value_next > FW'(ipv6p_pkg::PREFIX_MAX)) error_flag_next = 1'b1;
    fin_ok = !error_flag_next &&
             (gap_seen_next || group_count_next == 4'(ipv6p_pkg::NUM_GROUPS));

    // Expand the gap into zero groups
    k       = gap_seen_next ? (4'(ipv6p_pkg::NUM_GROUPS) - group_count_next) : 4'd0;
    gap_end = {1'b0, gap_position_next} + {1'b0, k};
    for (int i = 0; i < ipv6p_pkg::NUM_GROUPS; i++) begin
      gs_cur[i] = (wr_en && wr_idx == 3'(i)) ? wr_val : group_store[i];
    end
    flat = '0;
    for (int i = 0; i < ipv6p_pkg::NUM_GROUPS; i++) begin
      src = 5'(i) - {1'b0, k};
      if (!gap_seen_next || 5'(i) < {1'b0, gap_position_next}) v = gs_cur[i];
      else if (5'(i) < gap_end) v = '0;
      else v = gs_cur[src[2:0]];
      flat[2*HW-1-GW*i -: GW] = fin_ok ? v : '0;
    end
    fin_h0 = flat[2*HW-1:HW];
    fin_h1 = flat[HW-1:0];
    fin_plen = (fin_ok && prefix_mode >= ipv6p_pkg::MODE_PARSE && prefix_chars_next != 3'd0) ?
               $signed(prefix_value_next[PW-1:0]) : ipv6p_pkg::PLEN_NONE;
  end

  // Result pair register and skid
  logic                 pair_valid;
  logic                 sel;
  logic [HW-1:0]        pair_h0, pair_h1;
  logic                 pair_ok;
  logic signed [PW-1:0] pair_plen;
  logic                 sk_valid;
  logic [HW-1:0]        sk_h0, sk_h1;
  logic                 sk_ok;
  logic signed [PW-1:0] sk_plen;
  logic                 out_fire;
  logic                 pair_free;
  logic                 new_final;

  assign chars.ready = !sk_valid;
  assign in_fire     = chars.valid && chars.ready;
  assign new_final   = in_fire && chars.is_last;
  assign out_fire    = result.valid && result.ready;
  assign pair_free   = !pair_valid || (out_fire && sel);

  assign result.valid        = pair_valid;
  assign result.addr_half    = sel ? pair_h1 : pair_h0;
  assign result.half_index   = sel;
  assign result.parse_ok     = pair_ok;
  assign result.prefix_len   = pair_plen;
  assign result.final_result = sel;

  // Parse state and output control
  always_ff @(posedge clk) begin
    if (rst) begin
      group_count    <= '0;
      segment_value  <= '0;
      segment_digits <= '0;
      gap_position   <= '0;
      gap_seen       <= 1'b0;
      parse_phase    <= PH_NEW;
      address_chars  <= '0;
      error_flag     <= 1'b0;
      prefix_value   <= '0;
      prefix_chars   <= '0;
      pair_valid     <= 1'b0;
      sel            <= 1'b0;
      sk_valid       <= 1'b0;
    end else begin
      if (in_fire) begin
        if (chars.is_last) begin
          group_count    <= '0;
          segment_value  <= '0;
          segment_digits <= '0;
          gap_position   <= '0;
          gap_seen       <= 1'b0;
          parse_phase    <= PH_NEW;
          address_chars  <= '0;
          error_flag     <= 1'b0;
          prefix_value   <= '0;
          prefix_chars   <= '0;
        end else begin
          group_count    <= group_count_next;
          segment_value  <= segment_value_next;
          segment_digits <= segment_digits_next;
          gap_position   <= gap_position_next;
          gap_seen       <= gap_seen_next;
          parse_phase    <= parse_phase_next;
          address_chars  <= address_chars_next;
          error_flag     <= error_flag_next;
          prefix_value   <= prefix_value_next;
          prefix_chars   <= prefix_chars_next;
        end
      end
      if (out_fire && !sel) sel <= 1'b1;
      if (pair_free) begin
        if (sk_valid) begin
          pair_valid <= 1'b1;
          sel        <= 1'b0;
          sk_valid   <= 1'b0;
        end else if (new_final) begin
          pair_valid <= 1'b1;
          sel        <= 1'b0;
        end else begin
          pair_valid <= 1'b0;
        end
      end else if (new_final) begin
        sk_valid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire && wr_en) group_store[wr_idx] <= wr_val;
    if (pair_free && sk_valid) begin
      pair_h0   <= sk_h0;
      pair_h1   <= sk_h1;
      pair_ok   <= sk_ok;
      pair_plen <= sk_plen;
    end else if (pair_free && new_final) begin
      pair_h0   <= fin_h0;
      pair_h1   <= fin_h1;
      pair_ok   <= fin_ok;
      pair_plen <= fin_plen;
    end
    if (!pair_free && new_final) begin
      sk_h0   <= fin_h0;
      sk_h1   <= fin_h1;
      sk_ok   <= fin_ok;
      sk_plen <= fin_plen;
    end
  end

endmodule

// ===== design/ipv6p_checker.sv =====
// Port-level checks for the IPv6 text parser, bound to the top level.
// Depends on ipv6p_pkg and ipv6_text_address_parser_top_assert.svh.
`include "ipv6_text_address_parser_top_assert.svh"

module ipv6p_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                chars_valid,
  input logic                                chars_ready,
  input logic                                chars_is_last,
  input logic                                res_valid,
  input logic                                res_ready,
  input logic [ipv6p_pkg::HALF_W-1:0]        res_addr_half,
  input logic                                res_parse_ok,
  input logic signed [ipv6p_pkg::PLEN_W-1:0] res_prefix_len,
  input logic                                res_final
);

  // First half is always followed by the closing half
  `IPV6P_ASSERT_NXT(a_pair_order, clk, rst, res_valid && res_ready && !res_final, res_valid && res_final, "first half not followed by final half")

  // A failed parse reports a zero address and no prefix
  `IPV6P_ASSERT_IMP(a_fail_zero, clk, rst, res_valid && !res_parse_ok, res_addr_half == '0 && res_prefix_len == ipv6p_pkg::PLEN_NONE, "failed parse with nonzero payload")

  // Last character with an idle output gives a first half next cycle
  `IPV6P_ASSERT_NXT(a_last_to_out, clk, rst, chars_valid && chars_ready && chars_is_last && !res_valid, res_valid && !res_final, "end of text produced no result")

  // A result held under backpressure stays valid
  `IPV6P_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid, "result dropped while stalled")

endmodule

bind ipv6_text_address_parser_top ipv6p_checker u_ipv6p_checker (
  .clk            (clk),
  .rst            (rst),
  .chars_valid    (chars.valid),
  .chars_ready    (chars.ready),
  .chars_is_last  (chars.is_last),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .res_addr_half  (result.addr_half),
  .res_parse_ok   (result.parse_ok),
  .res_prefix_len (result.prefix_len),
  .res_final      (result.final_result)
);

// ===== tb/sv/tb_ipv6_text_address_parser_top.sv =====
// Self-checking testbench for the IPv6 text address parser top level.
// Uses ipv6p_pkg, ipv6p_char_if and ipv6p_result_if; a built-in parser model predicts
// the result beats of untyped texts, and directed texts are followed by random texts under varied idling.
module tb_ipv6_text_address_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  // Mode 3 has no package name; it behaves as prefix parsing
  localparam logic [ipv6p_pkg::MODE_W-1:0] MODE_PARSE_ALT = 2'd3;
  localparam logic [ipv6p_pkg::APB_ADDR_W-1:0] MODE_ADDR = {ipv6p_pkg::REG_PREFIX_MODE, 2'b00};

  localparam logic [ipv6p_pkg::CHAR_W-1:0] CH_LOWER_A  = "a";
  localparam logic [ipv6p_pkg::CHAR_W-1:0] CH_UPPER_A  = "A";
  localparam logic [ipv6p_pkg::CHAR_W-1:0] CH_NUL_MARK = "#";  // stands for NUL in directed texts

  // Parser scan states
  typedef enum logic [2:0] {
    ST_FIELD_START, ST_IN_FIELD, ST_AFTER_COLON, ST_PFX_DIGITS, ST_DISCARD, ST_PFX_TAIL
  } scan_state_t;

  typedef struct packed {
    logic [ipv6p_pkg::HALF_W-1:0]        half;
    logic                                idx;
    logic                                ok;
    logic signed [ipv6p_pkg::PLEN_W-1:0] plen;
    logic                                fin;
  } half_beat_t;

  typedef struct {
    string                               txt;
    logic [ipv6p_pkg::MODE_W-1:0]        mode;
    bit                                  typed;
    logic [ipv6p_pkg::HALF_W-1:0]        h0;
    logic [ipv6p_pkg::HALF_W-1:0]        h1;
    logic                                ok;
    logic signed [ipv6p_pkg::PLEN_W-1:0] plen;
  } dir_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ipv6p_pkg::APB_ADDR_W-1:0] paddr;
  logic [ipv6p_pkg::APB_DATA_W-1:0] pwdata;
  logic [ipv6p_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  ipv6p_char_if   char_bus ();
  ipv6p_result_if res_bus ();

  ipv6_text_address_parser_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (char_bus),
    .result  (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Parser model state
  logic [ipv6p_pkg::GROUP_W-1:0] grp_mem [ipv6p_pkg::NUM_GROUPS];
  logic [3:0]                    grp_cnt;
  logic [ipv6p_pkg::GROUP_W-1:0] fld_val;
  logic [2:0]                    fld_digits;
  logic [3:0]                    gap_at;
  logic                          gap_on;
  scan_state_t                   scan_st;
  logic [5:0]                    addr_chars_seen;
  logic                          bad;
  logic [ipv6p_pkg::PFX_W-1:0]   pfx_val;
  logic [2:0]                    pfx_chars;
  logic [ipv6p_pkg::MODE_W-1:0]  mode_shadow;

  half_beat_t                   addr_halves_due[$];
  logic [ipv6p_pkg::CHAR_W-1:0] text_buf[$];

  bit         use_typed;
  half_beat_t typed_pair[2];

  int fails;
  int cycle_cnt;
  int src_idle_pct;
  int sink_idle_pct;

  // Directed texts; typed rows carry their result, the rest go through the model
  dir_row_t dir_rows [25] = '{
    '{"::", ipv6p_pkg::MODE_NO_SLASH, 1'b1, 64'h0, 64'h0, 1'b1, ipv6p_pkg::PLEN_NONE},
    '{"1:2:3:4:5:6:7:8", ipv6p_pkg::MODE_NO_SLASH, 1'b1,
      64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008, 1'b1, ipv6p_pkg::PLEN_NONE},
    '{"ffff:FFFF:ffff:FFFF:ffff:ffff:ffff:ffff", ipv6p_pkg::MODE_NO_SLASH, 1'b1,
      64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, ipv6p_pkg::PLEN_NONE},
    '{"0000:0000:0000:0000:0000:0000:0000:0000:", ipv6p_pkg::MODE_NO_SLASH, 1'b1,
      64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"12345::", ipv6p_pkg::MODE_NO_SLASH, 1'b1, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"1:2:3:4:5:6:7:8:9", ipv6p_pkg::MODE_NO_SLASH, 1'b1,
      64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"1::2::3", ipv6p_pkg::MODE_NO_SLASH, 1'b1, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"1:2:3", ipv6p_pkg::MODE_NO_SLASH, 1'b1, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"1:2:3:4::5:6:7:8", ipv6p_pkg::MODE_NO_SLASH, 1'b0,
      64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"::ffff:1.2", ipv6p_pkg::MODE_NO_SLASH, 1'b1, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"fe80::1", ipv6p_pkg::MODE_NO_SLASH, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"1::", ipv6p_pkg::MODE_NO_SLASH, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{":::", ipv6p_pkg::MODE_NO_SLASH, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"1:2:3:4:5:6:7:8:", ipv6p_pkg::MODE_NO_SLASH, 1'b0,
      64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"::1#zz", ipv6p_pkg::MODE_NO_SLASH, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"#", ipv6p_pkg::MODE_NO_SLASH, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"a", ipv6p_pkg::MODE_NO_SLASH, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"::/64", ipv6p_pkg::MODE_NO_SLASH, 1'b1, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"1::/64", ipv6p_pkg::MODE_IGNORE, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"::/64", ipv6p_pkg::MODE_PARSE, 1'b1, 64'h0, 64'h0, 1'b1, 9'sd64},
    '{"::/128", MODE_PARSE_ALT, 1'b1, 64'h0, 64'h0, 1'b1, 9'sd128},
    '{"::/129", ipv6p_pkg::MODE_PARSE, 1'b1, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"::/1280", ipv6p_pkg::MODE_PARSE, 1'b1, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"::/", ipv6p_pkg::MODE_PARSE, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE},
    '{"::/12x", MODE_PARSE_ALT, 1'b0, 64'h0, 64'h0, 1'b0, ipv6p_pkg::PLEN_NONE}
  };

  localparam logic [ipv6p_pkg::MODE_W-1:0] MODE_ORDER [4] = '{
    ipv6p_pkg::MODE_PARSE, ipv6p_pkg::MODE_NO_SLASH, MODE_PARSE_ALT, ipv6p_pkg::MODE_IGNORE
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void note_fail(string msg);
    fails++;
    if (fails <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // ---------------------------------------------------------------- parser model
  function automatic int hex_val(logic [ipv6p_pkg::CHAR_W-1:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic void clear_text();
    grp_cnt         = '0;
    fld_val         = '0;
    fld_digits      = '0;
    gap_at          = '0;
    gap_on          = 1'b0;
    scan_st         = ST_FIELD_START;
    addr_chars_seen = '0;
    bad             = 1'b0;
    pfx_val         = '0;
    pfx_chars       = '0;
  endfunction

  function automatic void mark_bad();
    bad     = 1'b1;
    scan_st = ST_DISCARD;
  endfunction

  function automatic void close_group();
    if (grp_cnt >= 4'd8) begin
      mark_bad();
      return;
    end
    grp_mem[grp_cnt[2:0]] = fld_val;
    grp_cnt    = grp_cnt + 4'd1;
    fld_val    = '0;
    fld_digits = '0;
  endfunction

  function automatic void end_address();
    if (scan_st == ST_IN_FIELD) close_group();
  endfunction

  function automatic void take_addr_char(logic [ipv6p_pkg::CHAR_W-1:0] c);
    int d;
    d = hex_val(c);
    if (addr_chars_seen <= ipv6p_pkg::MAX_ADDR_CHARS_DEF) begin
      addr_chars_seen = addr_chars_seen + 6'd1;
    end
    if (addr_chars_seen > ipv6p_pkg::MAX_ADDR_CHARS_DEF) begin
      mark_bad();
      return;
    end
    if (c == ipv6p_pkg::CHAR_COLON) begin
      if (scan_st == ST_AFTER_COLON) begin
        // "::" - only one allowed
        if (gap_on) begin
          mark_bad();
          return;
        end
        gap_on  = 1'b1;
        gap_at  = grp_cnt;
        scan_st = ST_FIELD_START;
      end else begin
        close_group();
        if (!bad) scan_st = ST_AFTER_COLON;
      end
    end else if (d >= 0) begin
      if (scan_st != ST_IN_FIELD) begin
        fld_val    = '0;
        fld_digits = '0;
      end
      fld_digits = fld_digits + 3'd1;
      if (fld_digits > 3'd4) begin
        mark_bad();
        return;
      end
      fld_val = {fld_val[11:0], 4'(d)};
      scan_st = ST_IN_FIELD;
    end else begin
      mark_bad();
    end
  endfunction

  // One accepted character beat; on the last one, queue both result beats
  function automatic void advance_parser(logic [ipv6p_pkg::CHAR_W-1:0] c, bit last);
    bit in_addr;
    bit ok;
    int k;
    logic [ipv6p_pkg::GROUP_W-1:0] v;
    logic [ipv6p_pkg::HALF_W-1:0] h [2];
    logic signed [ipv6p_pkg::PLEN_W-1:0] plen;
    in_addr = (scan_st == ST_FIELD_START) || (scan_st == ST_IN_FIELD) ||
              (scan_st == ST_AFTER_COLON);
    if (in_addr) begin
      if (c == ipv6p_pkg::CHAR_NUL) begin
        end_address();
        if (!bad) scan_st = ST_DISCARD;
      end else if (c == ipv6p_pkg::CHAR_SLASH && mode_shadow != ipv6p_pkg::MODE_NO_SLASH) begin
        end_address();
        if (!bad) begin
          if (mode_shadow >= ipv6p_pkg::MODE_PARSE) begin
            scan_st   = ST_PFX_DIGITS;
            pfx_chars = 3'd1;
          end else begin
            scan_st = ST_DISCARD;
          end
        end
      end else begin
        take_addr_char(c);
      end
    end else if (scan_st == ST_PFX_DIGITS || scan_st == ST_PFX_TAIL) begin
      if (c == ipv6p_pkg::CHAR_NUL) begin
        scan_st = ST_DISCARD;
      end else begin
        if (pfx_chars < 3'd7) pfx_chars = pfx_chars + 3'd1;
        if (pfx_chars > 3'd4) begin
          bad = 1'b1;
        end else if (scan_st == ST_PFX_DIGITS && c >= ipv6p_pkg::CHAR_ZERO &&
                     c <= ipv6p_pkg::CHAR_NINE) begin
          pfx_val = pfx_val * 10 + ipv6p_pkg::PFX_W'(c - ipv6p_pkg::CHAR_ZERO);
        end else begin
          scan_st = ST_PFX_TAIL;
        end
      end
    end

    if (!last) return;

    if (scan_st == ST_FIELD_START || scan_st == ST_IN_FIELD || scan_st == ST_AFTER_COLON)
      end_address();
    if (pfx_val > ipv6p_pkg::PREFIX_MAX) bad = 1'b1;
    ok = !bad && (gap_on || grp_cnt == 4'd8);

    h[0] = '0;
    h[1] = '0;
    if (ok) begin
      // expand the gap into zero groups
      k = gap_on ? 8 - int'(grp_cnt) : 0;
      for (int i = 0; i < ipv6p_pkg::NUM_GROUPS; i++) begin
        if (i < int'(gap_at) || !gap_on) v = grp_mem[i & 7];
        else if (i < int'(gap_at) + k) v = '0;
        else v = grp_mem[(i - k) & 7];
        h[i / 4][63 - 16 * (i % 4) -: 16] = v;
      end
    end
    plen = (ok && mode_shadow >= ipv6p_pkg::MODE_PARSE && pfx_chars > 0) ?
           $signed({1'b0, pfx_val[7:0]}) : ipv6p_pkg::PLEN_NONE;

    for (int i = 0; i < 2; i++) begin
      if (use_typed) addr_halves_due.push_back(typed_pair[i]);
      else addr_halves_due.push_back('{h[i], 1'(i), ok, plen, 1'(i)});
    end
    clear_text();
  endfunction

  // ---------------------------------------------------------------- result check
  always @(posedge clk) begin
    half_beat_t got;
    half_beat_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got = '{res_bus.addr_half, res_bus.half_index, res_bus.parse_ok,
              res_bus.prefix_len, res_bus.final_result};
      if (addr_halves_due.size() == 0) begin
        note_fail($sformatf("unexpected result beat: half=%h idx=%0d ok=%0d plen=%0d fin=%0d",
                            got.half, got.idx, got.ok, got.plen, got.fin));
      end else begin
        want = addr_halves_due.pop_front();
        if (got.half !== want.half || got.idx !== want.idx || got.ok !== want.ok ||
            got.plen !== want.plen || got.fin !== want.fin) begin
          note_fail($sformatf({"result mismatch: exp half=%h idx=%0d ok=%0d plen=%0d fin=%0d",
                               " got half=%h idx=%0d ok=%0d plen=%0d fin=%0d"},
                              want.half, want.idx, want.ok, want.plen, want.fin,
                              got.half, got.idx, got.ok, got.plen, got.fin));
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_char(input logic [ipv6p_pkg::CHAR_W-1:0] c, input bit last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.is_last   <= last;
    @(posedge clk);
    while (!char_bus.ready) @(posedge clk);
    advance_parser(c, last);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1);
    end
  endtask

  // Block idle: wait for every result beat back, then drain
  task automatic settle();
    char_bus.valid <= 1'b0;
    while (addr_halves_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write prefix_mode with random upper bits, then read it back
  task automatic write_mode(input logic [ipv6p_pkg::MODE_W-1:0] m);
    logic [ipv6p_pkg::APB_DATA_W-1:0] wdata;
    wdata = $urandom;
    wdata[ipv6p_pkg::MODE_W-1:0] = m;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mode_shadow = m;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== ipv6p_pkg::APB_DATA_W'(m)) begin
      note_fail($sformatf("prefix_mode readback: exp %h got %h",
                          ipv6p_pkg::APB_DATA_W'(m), prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------- text generators
  function automatic logic [ipv6p_pkg::CHAR_W-1:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return ipv6p_pkg::CHAR_ZERO + ipv6p_pkg::CHAR_W'(v);
    if ($urandom_range(0, 1)) return CH_LOWER_A + ipv6p_pkg::CHAR_W'(v - 10);
    return CH_UPPER_A + ipv6p_pkg::CHAR_W'(v - 10);
  endfunction

  function automatic void put_group();
    repeat ($urandom_range(1, 4)) text_buf.push_back(rand_hex());
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void build_full();
    for (int g = 0; g < ipv6p_pkg::NUM_GROUPS; g++) begin
      if (g > 0) text_buf.push_back(ipv6p_pkg::CHAR_COLON);
      put_group();
    end
  endfunction

  function automatic void build_gap();
    int g;
    int p;
    g = $urandom_range(0, 8);
    p = $urandom_range(0, g);
    for (int i = 0; i < p; i++) begin
      if (i > 0) text_buf.push_back(ipv6p_pkg::CHAR_COLON);
      put_group();
    end
    put_str("::");
    for (int i = p; i < g; i++) begin
      if (i > p) text_buf.push_back(ipv6p_pkg::CHAR_COLON);
      put_group();
    end
  endfunction

  // Optional tail: a prefix, or a NUL with trailing junk
  function automatic void add_tail();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      text_buf.push_back(ipv6p_pkg::CHAR_SLASH);
      case ($urandom_range(0, 5))
        0: ;
        1: put_str($sformatf("%0d", $urandom_range(0, 128)));
        2: put_str($sformatf("%0d", $urandom_range(129, 999)));
        3: put_str($urandom_range(0, 1) ? "128" : "129");
        4: put_str($sformatf("%03d", $urandom_range(0, 200)));
        default: begin
          put_str($sformatf("%0d", $urandom_range(0, 99)));
          text_buf.push_back(ipv6p_pkg::CHAR_W'($urandom_range(0, 255)));
        end
      endcase
      if ($urandom_range(0, 7) == 0) begin
        text_buf.push_back(ipv6p_pkg::CHAR_W'($urandom_range(0, 255)));
      end
    end else if (r == 4) begin
      text_buf.push_back(ipv6p_pkg::CHAR_NUL);
      repeat ($urandom_range(0, 3)) begin
        text_buf.push_back(ipv6p_pkg::CHAR_W'($urandom_range(0, 255)));
      end
    end
  endfunction

  function automatic void make_random_text();
    int r;
    int pos;
    string charset;
    charset = "0123456789abcdefABCDEF::://";
    text_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 35) begin
      build_full();
      add_tail();
    end else if (r < 70) begin
      build_gap();
      add_tail();
    end else if (r < 85) begin
      // well-formed text with one defect
      if ($urandom_range(0, 1)) build_full();
      else build_gap();
      pos = $urandom_range(0, text_buf.size() - 1);
      case ($urandom_range(0, 4))
        0: text_buf[pos] = ipv6p_pkg::CHAR_W'($urandom_range(0, 255));
        1: text_buf.insert(pos, rand_hex());
        2: begin
          text_buf.push_back(ipv6p_pkg::CHAR_COLON);
          put_group();
        end
        3: begin
          text_buf.insert(pos, ipv6p_pkg::CHAR_COLON);
          text_buf.insert(pos, ipv6p_pkg::CHAR_COLON);
        end
        default: if (text_buf.size() > 1) text_buf.delete(pos);
      endcase
      add_tail();
    end else begin
      // noise
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 1)) begin
          text_buf.push_back(charset[$urandom_range(0, charset.len() - 1)]);
        end else begin
          text_buf.push_back(ipv6p_pkg::CHAR_W'($urandom_range(0, 255)));
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- main sequence
  initial begin
    int sent;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= '0;
    char_bus.is_last   <= 1'b0;
    fails         = 0;
    cycle_cnt     = 0;
    use_typed     = 1'b0;
    mode_shadow   = ipv6p_pkg::MODE_NO_SLASH;
    src_idle_pct  = 23;
    sink_idle_pct = 81;
    clear_text();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts
    foreach (dir_rows[r]) begin
      if (dir_rows[r].mode != mode_shadow) begin
        settle();
        write_mode(dir_rows[r].mode);
      end
      use_typed     = dir_rows[r].typed;
      typed_pair[0] = '{dir_rows[r].h0, 1'b0, dir_rows[r].ok, dir_rows[r].plen, 1'b0};
      typed_pair[1] = '{dir_rows[r].h1, 1'b1, dir_rows[r].ok, dir_rows[r].plen, 1'b1};
      text_buf.delete();
      for (int j = 0; j < dir_rows[r].txt.len(); j++) begin
        text_buf.push_back(dir_rows[r].txt[j] == CH_NUL_MARK ? ipv6p_pkg::CHAR_NUL
                                                             : dir_rows[r].txt[j]);
      end
      send_text();
    end
    use_typed = 1'b0;

    // Random texts: three idling patterns, each through all four modes
    for (int ph = 0; ph < 3; ph++) begin
      for (int m = 0; m < 4; m++) begin
        settle();
        src_idle_pct  = (ph == 0) ? 23 : (ph == 1) ? 81 : 0;
        sink_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 23 : 0;
        write_mode(MODE_ORDER[m]);
        sent = 0;
        while (sent < 100) begin
          make_random_text();
          sent += text_buf.size();
          send_text();
        end
      end
    end

    settle();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
